### src/lfr_pkg.sv
// ============================================================================
// lfr_pkg - shared types and constants for the length-prefixed frame receiver
// Input kind codes, register map, reset values and controller/datapath structs.
// ============================================================================
`default_nettype none

package lfr_pkg;

    // input item kinds (carried on tuser)
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_OVERRUN = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_START   = 2'd0;
    localparam logic [1:0] REG_STOP    = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // register reset values
    localparam logic [7:0]  RST_START   = 8'hAA;
    localparam logic [7:0]  RST_STOP    = 8'h55;
    localparam logic [6:0]  RST_MAX_LEN = 7'd64;
    localparam logic [15:0] RST_TIMEOUT = 16'd10000;

    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    // controller -> datapath
    typedef struct packed {
        logic idle_tick;   // count one millisecond
        logic idle_clear;  // byte received
        logic load_len;    // latch length byte, clear stored count
        logic store_byte;  // write payload byte to the store
        logic rd_start;    // reset readout index
        logic rd_issue;    // read store at readout index
        logic rd_load;     // capture read data into output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic timeout;     // idle count above timeout
        logic is_start;    // byte equals start marker
        logic is_stop;     // byte equals stop marker
        logic len_ok;      // byte is an acceptable length
        logic data_done;   // this byte completes the payload
        logic out_free;    // output register can take a new result
        logic rd_last;     // current readout index is the final byte
    } t_dp_status;

endpackage

`default_nettype wire

### src/lfr_ram.sv
// ============================================================================
// lfr_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module lfr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/lfr_datapath.sv
// ============================================================================
// lfr_datapath - registers, counters, payload store and output register
// Executes controller commands and reports compare results back.
// ============================================================================
`default_nettype none

module lfr_datapath import lfr_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    // input byte
    input  wire logic [7:0]  i_data,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_out_byte,
    output logic      [5:0]  o_out_idx,
    output logic      [6:0]  o_out_len,
    output logic             o_out_last,
    // control
    input  wire t_ctrl_cmd   i_cmd,
    output t_dp_status       o_status
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  r_start, r_stop;
    logic [6:0]  r_max_len;
    logic [15:0] r_timeout;

    logic [16:0]      r_idle;
    logic [6:0]       r_declared;
    logic [CNT_W-1:0] r_stored;
    logic [CNT_W-1:0] r_rd_idx;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [5:0] r_out_idx;
    logic [6:0] r_out_len;
    logic       r_out_last;

    logic       cfg_wr;
    logic       store_we;
    logic [7:0] ram_rdata;
    logic [8:0] stored_next;
    logic [8:0] rd_next;

    assign cfg_wr      = psel & penable & pwrite;
    assign stored_next = 9'(r_stored) + 9'd1;
    assign rd_next     = 9'(r_rd_idx) + 9'd1;
    assign store_we    = i_cmd.store_byte & (9'(r_stored) < 9'(MAX_PAYLOAD));

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= RST_START;
            r_stop    <= RST_STOP;
            r_max_len <= RST_MAX_LEN;
            r_timeout <= RST_TIMEOUT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_START:   r_start   <= pwdata[7:0];
                REG_STOP:    r_stop    <= pwdata[7:0];
                REG_MAX_LEN: r_max_len <= pwdata[6:0];
                REG_TIMEOUT: r_timeout <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START:   prdata = {24'd0, r_start};
            REG_STOP:    prdata = {24'd0, r_stop};
            REG_MAX_LEN: prdata = {25'd0, r_max_len};
            REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:     prdata = 32'd0;
        endcase
    end

    // idle counter, frame counters, readout index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle     <= '0;
            r_declared <= '0;
            r_stored   <= '0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cmd.idle_clear) begin
                r_idle <= '0;
            end else if (i_cmd.idle_tick && r_idle != IDLE_MAX) begin
                r_idle <= r_idle + 17'd1;
            end
            if (i_cmd.load_len) begin
                r_declared <= i_data[6:0];
                r_stored   <= '0;
            end else if (store_we) begin
                r_stored <= CNT_W'(stored_next);
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_load) begin
                r_rd_idx <= CNT_W'(rd_next);
            end
        end
    end

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_stored[ADDR_W-1:0]),
        .i_wdata (i_data),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_load) begin
            r_out_byte <= ram_rdata;
            r_out_idx  <= 6'(r_rd_idx);
            r_out_len  <= r_declared;
            r_out_last <= o_status.rd_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_idx   = r_out_idx;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

    // status
    assign o_status.timeout   = r_idle > {1'b0, r_timeout};
    assign o_status.is_start  = i_data == r_start;
    assign o_status.is_stop   = i_data == r_stop;
    assign o_status.len_ok    = (i_data != 8'd0) && (i_data <= {1'b0, r_max_len})
                              && (9'(i_data) <= 9'(MAX_PAYLOAD));
    assign o_status.data_done = stored_next >= 9'(r_declared);
    assign o_status.out_free  = ~r_out_valid | i_out_ready;
    assign o_status.rd_last   = rd_next == 9'(r_declared);

    // no write beyond the store
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_byte |-> (9'(r_stored) < 9'(MAX_PAYLOAD)))
        else $error("payload write past store depth");

    // a captured result is presented next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_load |=> r_out_valid)
        else $error("loaded result not valid");

    // an accepted length is never zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_len |=> (r_declared != 7'd0))
        else $error("zero length latched");

endmodule

`default_nettype wire

### src/lfr_ctrl.sv
// ============================================================================
// lfr_ctrl - frame parse and readout sequencer
// Tracks the parse phase, decodes input kinds and walks the store on a good stop.
// ============================================================================
`default_nettype none

module lfr_ctrl import lfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_kind,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [2:0] S_HUNT     = 3'd0;
    localparam logic [2:0] S_LENGTH   = 3'd1;
    localparam logic [2:0] S_DATA     = 3'd2;
    localparam logic [2:0] S_STOP     = 3'd3;
    localparam logic [2:0] S_RD_ISSUE = 3'd4;
    localparam logic [2:0] S_RD_WAIT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       in_acc;

    assign o_in_ready = r_state inside {S_HUNT, S_LENGTH, S_DATA, S_STOP};
    assign in_acc     = o_in_ready & i_in_valid;

    always_comb begin
        logic [2:0] eff;
        eff     = i_status.timeout ? S_HUNT : r_state;
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT, S_LENGTH, S_DATA, S_STOP: begin
                if (in_acc) begin
                    case (i_kind)
                        KIND_TICK:    o_cmd.idle_tick = 1'b1;
                        KIND_OVERRUN: n_state = S_HUNT;
                        KIND_BYTE: begin
                            o_cmd.idle_clear = 1'b1;
                            case (eff)
                                S_HUNT: begin
                                    n_state = i_status.is_start ? S_LENGTH : S_HUNT;
                                end
                                S_LENGTH: begin
                                    if (i_status.len_ok) begin
                                        o_cmd.load_len = 1'b1;
                                        n_state        = S_DATA;
                                    end else begin
                                        n_state = S_HUNT;
                                    end
                                end
                                S_DATA: begin
                                    o_cmd.store_byte = 1'b1;
                                    if (i_status.data_done) begin
                                        n_state = S_STOP;
                                    end
                                end
                                default: begin
                                    if (i_status.is_stop) begin
                                        o_cmd.rd_start = 1'b1;
                                        n_state        = S_RD_ISSUE;
                                    end else begin
                                        n_state = S_HUNT;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_ISSUE: begin
                if (i_status.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_load = 1'b1;
                n_state       = i_status.rd_last ? S_HUNT : S_RD_ISSUE;
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // store read data is captured only in the cycle after the read
    a_load_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_load |-> $past(o_cmd.rd_issue))
        else $error("result load without store read");

    // never read while the output register is still occupied
    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |-> i_status.out_free)
        else $error("store read with output register busy");

    // final byte ends the readout
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_WAIT && i_status.rd_last) |=> (r_state == S_HUNT))
        else $error("readout did not end after final byte");

endmodule

`default_nettype wire

### src/length_prefixed_frame_receiver_core.sv
// Readout: a good stop byte sends the controller through S_RD_ISSUE (store read, held
//   while the output register is occupied) and S_RD_WAIT (capture into the output register).
// Throughput: one input transfer per cycle while parsing; after a good stop the
//   store is read out one payload byte at a time (one RAM read port) and no
//   input is taken until the final result is in the output register.
// Reset: synchronous active low; parse state and registers to defaults, store kept.
// ============================================================================
// length_prefixed_frame_receiver_core - start/length/payload/stop deframer
// Hunts for a start byte, checks the length, stores the payload, verifies
// the stop byte and streams the payload out one byte per transfer.
// ============================================================================
`default_nettype none

module length_prefixed_frame_receiver_core import lfr_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,   // [7:0] payload_byte, [13:8] byte_index,
                                               // [20:14] frame_length, [23:21] zero
    output logic             o_m_axis_tlast,   // last_byte
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    logic [7:0] out_byte;
    logic [5:0] out_idx;
    logic [6:0] out_len;

    assign pready = 1'b1;

    // phase tracking and readout sequencing
    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // registers, counters, store and output register
    lfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_data      (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_byte  (out_byte),
        .o_out_idx   (out_idx),
        .o_out_len   (out_len),
        .o_out_last  (o_m_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    assign o_m_axis_tdata = {3'd0, out_len, out_idx, out_byte};

endmodule

`default_nettype wire

### tb/lfr_frame_check_pkg.sv
// ============================================================================
// lfr_frame_check_pkg - payload scoreboard for the frame receiver bench
// Tracks the deframer state from the accepted input transfers, queues the
// payload transfers a good stop byte must produce and checks the result stream.
// ============================================================================
package lfr_frame_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;

    localparam int         PAYLOAD_DEPTH = 64;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        SEEK_START,
        READ_LENGTH,
        FILL_PAYLOAD,
        AWAIT_STOP
    } rx_phase_e;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic [6:0] frame_length;
        logic       last_byte;
    } payload_beat_t;

    class frame_scoreboard;
        logic [7:0]    start_byte;
        logic [7:0]    stop_byte;
        logic [6:0]    len_limit;
        logic [15:0]   timeout_ms;

        rx_phase_e     phase;
        int unsigned   frame_len;
        int unsigned   fill_count;
        logic [16:0]   idle_count;
        logic [7:0]    payload_mem [PAYLOAD_DEPTH];

        payload_beat_t beats_due [$];
        int unsigned   mismatches;
        int unsigned   beats_checked;
        int unsigned   frames_delivered;

        function new();
            start_byte       = RST_START;
            stop_byte        = RST_STOP;
            len_limit        = RST_MAX_LEN;
            timeout_ms       = RST_TIMEOUT;
            idle_count       = '0;
            mismatches       = 0;
            beats_checked    = 0;
            frames_delivered = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            phase      = SEEK_START;
            frame_len  = 0;
            fill_count = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_START:   start_byte = value[7:0];
                REG_STOP:    stop_byte  = value[7:0];
                REG_MAX_LEN: len_limit  = value[6:0];
                default:     timeout_ms = value[15:0];
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_START:   return {24'd0, start_byte};
                REG_STOP:    return {24'd0, stop_byte};
                REG_MAX_LEN: return {25'd0, len_limit};
                default:     return {16'd0, timeout_ms};
            endcase
        endfunction

        function void check_readback(logic [1:0] idx, logic [31:0] got);
            if (got !== reg_value(idx)) begin
                flag($sformatf("register %0d read back: expected %h, got %h",
                               idx, reg_value(idx), got));
            end
        endfunction

        function int unsigned pending();
            return beats_due.size();
        endfunction

        // advance the deframer by one accepted transfer
        function void note_input(logic [1:0] kind, logic [7:0] data);
            payload_beat_t beat;
            int unsigned   k;
            case (kind)
                KIND_TICK: begin
                    if (idle_count != IDLE_MAX) idle_count++;
                end
                KIND_OVERRUN: restart_hunt();
                KIND_BYTE: begin
                    // stale partial frame is dropped before the byte is parsed
                    if (idle_count > {1'b0, timeout_ms}) restart_hunt();
                    idle_count = '0;
                    case (phase)
                        SEEK_START: begin
                            if (data == start_byte) phase = READ_LENGTH;
                        end
                        READ_LENGTH: begin
                            if (data != 8'd0 && data <= len_limit
                                && data <= PAYLOAD_DEPTH) begin
                                frame_len  = data;
                                fill_count = 0;
                                phase      = FILL_PAYLOAD;
                            end else begin
                                restart_hunt();
                            end
                        end
                        FILL_PAYLOAD: begin
                            if (fill_count < PAYLOAD_DEPTH) begin
                                payload_mem[fill_count] = data;
                                fill_count++;
                            end
                            if (fill_count >= frame_len) phase = AWAIT_STOP;
                        end
                        default: begin
                            if (data == stop_byte) begin
                                for (k = 0; k < frame_len && k < PAYLOAD_DEPTH; k++) begin
                                    beat.payload_byte = payload_mem[k];
                                    beat.byte_index   = k[5:0];
                                    beat.frame_length = frame_len[6:0];
                                    beat.last_byte    = (k + 1 == frame_len);
                                    beats_due.push_back(beat);
                                end
                            end
                            restart_hunt();
                        end
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [23:0] tdata, logic tlast);
            payload_beat_t got;
            payload_beat_t want;
            got = {tdata[7:0], tdata[13:8], tdata[20:14], tlast};
            beats_checked++;
            if (beats_due.size() == 0) begin
                flag($sformatf({"unexpected payload transfer: expected none, got byte %h",
                                " index %0d length %0d last %b"},
                               got.payload_byte, got.byte_index, got.frame_length,
                               got.last_byte));
            end else begin
                want = beats_due.pop_front();
                if (want.last_byte) frames_delivered++;
                if (got !== want) begin
                    flag($sformatf({"payload mismatch: expected byte %h index %0d length %0d",
                                    " last %b, got byte %h index %0d length %0d last %b"},
                                   want.payload_byte, want.byte_index, want.frame_length,
                                   want.last_byte, got.payload_byte, got.byte_index,
                                   got.frame_length, got.last_byte));
                end
            end
        endfunction
    endclass

endpackage

### tb/tb_length_prefixed_frame_receiver_core.sv
// ============================================================================
// tb_length_prefixed_frame_receiver_core - self-checking bench for the deframer
// Drives byte, tick and overrun transfers through the input stream, programs
// the markers, length limit and idle timeout over APB between phases, and
// checks every payload transfer against a scoreboard that tracks the parser.
// ============================================================================
module tb_length_prefixed_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;
    import lfr_frame_check_pkg::*;

    localparam int DRAIN_CYCLES   = 16;      // covers readout start after a silent drop

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // [7:0] data_byte
    logic [1:0]  i_s_axis_tuser  = '0;   // [1:0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // [7:0] payload_byte, [13:8] byte_index,
                                         // [20:14] frame_length, [23:21] zero
    logic        o_m_axis_tlast;         // last_byte
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    // percentages of cycles in which the sender idles / the receiver stalls
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned events_sent    = 0;

    frame_scoreboard board;

    length_prefixed_frame_receiver_core #(
        .MAX_PAYLOAD (PAYLOAD_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: a transfer completes at an edge with tvalid and tready high.
    // Outputs are read at the edge before any register update lands, and the
    // next tready is rolled for the following cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                board.check_result(o_m_axis_tdata, o_m_axis_tlast);
            end
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // One input transfer. Idle cycles are inserted first, then tvalid stays
    // up until the block takes it. Returns at the accepting edge, so the next
    // call can keep tvalid high back to back with a single assignment.
    task automatic push_event(logic [1:0] kind, logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_input(kind, data);
        if (kind != KIND_UNUSED) events_sent++;
    endtask

    // start, length, random payload (a stray tick now and then, never enough to
    // time out), closing byte
    task automatic send_frame(logic [7:0] len_byte, logic [7:0] close_byte,
                              int unsigned n_data);
        push_event(KIND_BYTE, board.start_byte);
        push_event(KIND_BYTE, len_byte);
        repeat (n_data) begin
            if (board.timeout_ms > 1 && $urandom_range(9) == 0) begin
                push_event(KIND_TICK, 8'($urandom));
            end
            push_event(KIND_BYTE, 8'($urandom));
        end
        push_event(KIND_BYTE, close_byte);
    endtask

    // mostly short frames; the longest legal length one time in ten
    function automatic logic [7:0] pick_length();
        int unsigned cap;
        cap = (board.len_limit > 8) ? 8 : board.len_limit;
        if (board.len_limit == 0) return 8'($urandom_range(1, 8));
        if ($urandom_range(9) == 0) return {1'b0, board.len_limit};
        return 8'($urandom_range(1, cap));
    endfunction

    task automatic run_random(int unsigned n_events);
        int unsigned goal;
        int unsigned pick;
        int unsigned lim;
        logic [7:0]  len;
        logic [7:0]  bad;
        goal = events_sent + n_events;
        while (events_sent < goal) begin
            pick = $urandom_range(99);
            len  = pick_length();
            lim  = board.len_limit;
            if (pick < 55) begin
                send_frame(len, board.stop_byte, len);
            end else if (pick < 65) begin
                // one bit off in the closing byte
                send_frame(len, board.stop_byte ^ (8'h01 << $urandom_range(7)), len);
            end else if (pick < 73) begin
                case ($urandom_range(2))
                    0:       bad = 8'd0;
                    1:       bad = 8'(lim + 1);
                    default: bad = 8'($urandom_range(lim + 1, 255));
                endcase
                push_event(KIND_BYTE, board.start_byte);
                push_event(KIND_BYTE, bad);
            end else if (pick < 80) begin
                // overrun anywhere from the first payload byte to the stop wait
                push_event(KIND_BYTE, board.start_byte);
                push_event(KIND_BYTE, len);
                repeat ($urandom_range(0, len)) push_event(KIND_BYTE, 8'($urandom));
                push_event(KIND_OVERRUN, 8'($urandom));
            end else if (pick < 88) begin
                // partial frame, a silence past the timeout where that is
                // reachable, then a fresh frame that must restart the hunt
                push_event(KIND_BYTE, board.start_byte);
                push_event(KIND_BYTE, len);
                push_event(KIND_BYTE, 8'($urandom));
                repeat ((board.timeout_ms <= 64) ? board.timeout_ms + $urandom_range(1, 3)
                                                 : $urandom_range(1, 3)) begin
                    push_event(KIND_TICK, 8'($urandom));
                end
                send_frame(len, board.stop_byte, len);
            end else begin
                repeat ($urandom_range(1, 4)) push_event(2'($urandom), 8'($urandom));
            end
        end
    endtask

    // stop sending and let every queued payload transfer come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then a read of the same register, then the bus returns to idle
    task automatic program_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.check_readback(idx, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- reset settings, no idling: directed cases ----
        push_event(KIND_BYTE, 8'h00);                  // noise while hunting
        push_event(KIND_BYTE, board.start_byte);       // shortest frame, zero byte
        push_event(KIND_BYTE, 8'd1);
        push_event(KIND_BYTE, 8'h00);
        push_event(KIND_BYTE, board.stop_byte);
        push_event(KIND_BYTE, board.start_byte);       // tick inside the payload
        push_event(KIND_BYTE, 8'd3);
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_TICK, 8'h00);
        push_event(KIND_BYTE, 8'h80);
        push_event(KIND_BYTE, 8'h7F);
        push_event(KIND_BYTE, board.stop_byte);
        push_event(KIND_UNUSED, board.start_byte);     // unused kind, no effect
        push_event(KIND_BYTE, board.start_byte);       // zero length
        push_event(KIND_BYTE, 8'd0);
        push_event(KIND_BYTE, board.start_byte);       // one above the limit
        push_event(KIND_BYTE, 8'd65);
        push_event(KIND_BYTE, board.start_byte);       // wrong stop byte
        push_event(KIND_BYTE, 8'd1);
        push_event(KIND_BYTE, 8'h5A);
        push_event(KIND_BYTE, 8'h56);
        push_event(KIND_BYTE, board.start_byte);       // overrun mid-payload
        push_event(KIND_BYTE, 8'd2);
        push_event(KIND_BYTE, 8'h11);
        push_event(KIND_OVERRUN, 8'hFF);
        run_random(20);

        // ---- low extremes, sender mostly idle ----
        drain();
        src_idle_pct   = 88;
        sink_stall_pct = 0;
        program_reg(REG_START, 32'h00);
        program_reg(REG_STOP, 32'hFF);
        program_reg(REG_MAX_LEN, 32'd1);
        program_reg(REG_TIMEOUT, 32'd0);
        // zero timeout: a single tick makes the next byte restart the hunt
        push_event(KIND_BYTE, 8'h00);
        push_event(KIND_BYTE, 8'd1);
        push_event(KIND_TICK, 8'h00);
        push_event(KIND_BYTE, 8'h00);
        push_event(KIND_BYTE, 8'd1);
        push_event(KIND_BYTE, 8'h7E);
        push_event(KIND_BYTE, 8'hFF);
        run_random(25);

        // ---- high markers, short timeout, receiver mostly stalled ----
        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 88;
        program_reg(REG_START, 32'hFF);
        program_reg(REG_STOP, 32'h00);
        program_reg(REG_MAX_LEN, 32'd64);
        program_reg(REG_TIMEOUT, 32'd3);
        // idle equal to the timeout keeps the frame
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_BYTE, 8'd2);
        repeat (3) push_event(KIND_TICK, 8'h00);
        push_event(KIND_BYTE, 8'hAB);
        push_event(KIND_BYTE, 8'hCD);
        push_event(KIND_BYTE, 8'h00);
        // one tick more drops it
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_BYTE, 8'd1);
        repeat (4) push_event(KIND_TICK, 8'h00);
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_BYTE, 8'd1);
        push_event(KIND_BYTE, 8'h33);
        push_event(KIND_BYTE, 8'h00);
        run_random(30);

        // ---- random markers, widest timeout, both sides idling ----
        drain();
        src_idle_pct   = 25;
        sink_stall_pct = 25;
        program_reg(REG_START, 32'($urandom_range(255)));
        program_reg(REG_STOP, 32'($urandom_range(255)));
        program_reg(REG_MAX_LEN, 32'($urandom_range(2, 63)));
        program_reg(REG_TIMEOUT, 32'hFFFF);
        run_random(30);

        // ---- zero length limit: every frame is rejected ----
        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        program_reg(REG_MAX_LEN, 32'd0);
        run_random(8);

        // ---- full length limit, new markers ----
        drain();
        program_reg(REG_START, 32'($urandom_range(255)));
        program_reg(REG_STOP, 32'($urandom_range(255)));
        program_reg(REG_MAX_LEN, 32'd64);
        run_random(22);

        drain();
        $display("Run covered %0d input transfers under six register settings and four idle",
                 events_sent);
        $display("profiles; %0d payload transfers checked in %0d delivered frames.",
                 board.beats_checked, board.frames_delivered);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, several times the slowest expected run
    initial begin
        #10ms;
        $display("%0t: run did not complete, %0d payload transfers outstanding",
                 $time, board.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
